>>> src/circular_delay_line_controller_top_defines.svh
// Assertion macros for the circular delay line controller.
`ifndef CIRCULAR_DELAY_LINE_CONTROLLER_TOP_DEFINES_SVH
`define CIRCULAR_DELAY_LINE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset
`define CDL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdl check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define CDL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdl check failed");

`else

`define CDL_ASSERT_IMPL(label, ante, cons)
`define CDL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/cdl_pkg.sv
// Shared types and constants for the circular delay line controller.
`default_nettype none

package cdl_pkg;

    localparam int PTR_W    = 16;
    localparam int LEN_W    = PTR_W + 1;
    localparam int SAMPLE_W = 32;

    // Request codes
    typedef enum logic [3:0] {
        REQ_WRITE          = 4'd0,
        REQ_READ           = 4'd1,
        REQ_PEEK           = 4'd2,
        REQ_MOVE           = 4'd3,
        REQ_MOVE_READ_NEXT = 4'd4,
        REQ_MOVE_READ      = 4'd5,
        REQ_READ_STEP      = 4'd6,
        REQ_BACK           = 4'd7,
        REQ_BOTH           = 4'd8,
        REQ_SWAP           = 4'd9,
        REQ_CLEAR          = 4'd10
    } req_type_t;

    // Modulo unit request and response
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [PTR_W-1:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

>>> src/circular_delay_line_controller_top.sv
// Circular delay line controller: ring memory, request sequencer and stream ports.
//
// Ring of samples in one single-port synchronous memory with independent read and
// write pointers that wrap after ring_last. One request in, one result out. A request
// goes through decode, the wrap unit once per pointer sum it needs (none for step
// back, swap, ignored and unknown requests), a memory state for reads and writes, and
// the finish state. A wrap is taken from the sum directly, but when a pointer lies
// beyond a ring that was shortened, the shared wrap unit forms the full remainder
// one bit a cycle. Clear walks the memory one entry a cycle, from 0 to ring_last,
// then finishes. The next request is taken while a result waits on the
// output. RING_DEPTH is a power of two; ring indexes address the memory modulo it.
// Ring contents are undefined after reset: issue a clear before use.
`default_nettype none
`include "circular_delay_line_controller_top_defines.svh"

module circular_delay_line_controller_top
    import cdl_pkg::*;
#(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // sample_in[31:0], offset[47:32]
    input  wire logic [3:0]  s_axis_tuser,   // req_type[3:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // sample_out[31:0], read_position[47:32],
                                             // write_position[63:48]
    output logic [0:0]       m_axis_tuser,   // status[0]
    // ring_last register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int ADDR_W = $clog2(RING_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_MOD    = 6'b000100,
        ST_MEM    = 6'b001000,
        ST_CLEAR  = 6'b010000,
        ST_FIN    = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    req_type_t        req_reg, req_next;
    logic [PTR_W-1:0] ring_last_reg, ring_last_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] clr_idx_reg, clr_idx_next;
    logic             step_reg, step_next;
    logic             status_reg, status_next;
    logic             res_read_reg, res_read_next;
    logic             m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [PTR_W-1:0] offset_reg, offset_next;
    logic [PTR_W-1:0] addr_reg, addr_next;
    logic [63:0]      m_data_reg, m_data_next;
    logic             m_user_reg, m_user_next;

    logic [LEN_W-1:0] ring_len;
    logic [LEN_W-1:0] rp_inc, wp_inc, rp_off, rp_off_inc;
    logic [LEN_W-1:0] first_div, second_div;
    logic             off_bad, needs_mod, needs_second, out_free;
    logic [SAMPLE_W-1:0] sample_out;

    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    // Ring memory
    logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic             mem_we, mem_re;
    logic [PTR_W-1:0] mem_idx;
    logic [ADDR_W-1:0] mem_addr;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Pointer sums ahead of the wrap unit
    assign ring_len   = {1'b0, ring_last_reg} + LEN_W'(1);
    assign rp_inc     = {1'b0, rd_ptr_reg} + LEN_W'(1);
    assign wp_inc     = {1'b0, wr_ptr_reg} + LEN_W'(1);
    assign rp_off     = {1'b0, rd_ptr_reg} + {1'b0, offset_reg};
    assign rp_off_inc = rp_off + LEN_W'(1);

    assign off_bad = (req_reg inside {[REQ_PEEK:REQ_READ_STEP]})
                     && ({1'b0, offset_reg} >= ring_len);

    always_comb
    begin
        case (req_reg)
            REQ_WRITE:          first_div = wp_inc;
            REQ_READ,
            REQ_BOTH:           first_div = rp_inc;
            REQ_MOVE_READ_NEXT: first_div = rp_off_inc;
            default:            first_div = rp_off;
        endcase
    end

    assign second_div   = (req_reg == REQ_BOTH) ? wp_inc : rp_inc;
    assign needs_mod    = req_reg inside {[REQ_WRITE:REQ_READ_STEP], REQ_BOTH};
    assign needs_second = (req_reg == REQ_READ_STEP) || (req_reg == REQ_BOTH);

    // Wrap unit requests: first sum from decode, second sum when the first returns
    assign mod_req.start = ((state_reg == ST_DECODE) && !off_bad && needs_mod)
                           || ((state_reg == ST_MOD) && mod_rsp.done
                               && needs_second && !step_reg);
    assign mod_req.dividend = (state_reg == ST_MOD) ? second_div : first_div;
    assign mod_req.divisor  = ring_len;

    cdl_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .mod_req (mod_req),
        .mod_rsp (mod_rsp)
    );

    // Memory port control
    assign mem_we    = ((state_reg == ST_MEM) && (req_reg == REQ_WRITE))
                       || (state_reg == ST_CLEAR);
    assign mem_re    = (state_reg == ST_MEM) && (req_reg != REQ_WRITE);
    assign mem_idx   = (state_reg == ST_CLEAR) ? clr_idx_reg : addr_reg;
    assign mem_addr  = ADDR_W'(mem_idx);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : sample_reg[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= ring_mem[mem_addr];
    end

    assign sample_out = res_read_reg ? SAMPLE_W'(rdata_reg) : '0;

    // Request sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        ring_last_next = ring_last_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        clr_idx_next   = clr_idx_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        res_read_next  = res_read_reg;
        sample_next    = sample_reg;
        offset_next    = offset_reg;
        addr_next      = addr_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_valid_next   = m_valid_reg;

        if (cfg_valid)
            ring_last_next = cfg_data;
        if (m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next    = req_type_t'(s_axis_tuser);
                    sample_next = s_axis_tdata[31:0];
                    offset_next = s_axis_tdata[47:32];
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                status_next   = 1'b0;
                res_read_next = 1'b0;
                step_next     = 1'b0;
                if (off_bad)
                begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end
                else if (needs_mod)
                    state_next = ST_MOD;
                else
                begin
                    state_next = ST_FIN;
                    case (req_reg)
                        REQ_BACK:
                        begin
                            if (rd_ptr_reg == '0)
                                rd_ptr_next = ring_last_reg;
                            else if ((rd_ptr_reg - PTR_W'(1)) >= ring_last_reg)
                                rd_ptr_next = ring_last_reg;
                            else
                                rd_ptr_next = rd_ptr_reg - PTR_W'(1);
                        end
                        REQ_SWAP:
                        begin
                            rd_ptr_next = wr_ptr_reg;
                            wr_ptr_next = rd_ptr_reg;
                        end
                        REQ_CLEAR:
                        begin
                            clr_idx_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    if (!step_reg)
                    begin
                        case (req_reg)
                            REQ_WRITE:
                            begin
                                wr_ptr_next = mod_rsp.rem;
                                addr_next   = mod_rsp.rem;
                                state_next  = ST_MEM;
                            end
                            REQ_READ,
                            REQ_MOVE_READ_NEXT,
                            REQ_MOVE_READ:
                            begin
                                rd_ptr_next = mod_rsp.rem;
                                addr_next   = mod_rsp.rem;
                                state_next  = ST_MEM;
                            end
                            REQ_PEEK:
                            begin
                                addr_next  = mod_rsp.rem;
                                state_next = ST_MEM;
                            end
                            REQ_MOVE:
                            begin
                                rd_ptr_next = mod_rsp.rem;
                                state_next  = ST_FIN;
                            end
                            REQ_READ_STEP:
                            begin
                                addr_next = mod_rsp.rem;
                                step_next = 1'b1;
                            end
                            REQ_BOTH:
                            begin
                                rd_ptr_next = mod_rsp.rem;
                                step_next   = 1'b1;
                            end
                            default:
                            begin
                                state_next = ST_FIN;
                            end
                        endcase
                    end
                    else if (req_reg == REQ_READ_STEP)
                    begin
                        rd_ptr_next = mod_rsp.rem;
                        state_next  = ST_MEM;
                    end
                    else
                    begin
                        wr_ptr_next = mod_rsp.rem;
                        state_next  = ST_FIN;
                    end
                end
            end
            ST_MEM:
            begin
                res_read_next = (req_reg != REQ_WRITE);
                state_next    = ST_FIN;
            end
            ST_CLEAR:
            begin
                // one entry zeroed per cycle
                if (clr_idx_reg == ring_last_reg)
                begin
                    clr_idx_next = '0;
                    state_next   = ST_FIN;
                end
                else
                    clr_idx_next = clr_idx_reg + PTR_W'(1);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {wr_ptr_reg, rd_ptr_reg, sample_out};
                    m_user_next  = status_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= REQ_WRITE;
            ring_last_reg <= 16'hFFFF;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            clr_idx_reg   <= '0;
            step_reg      <= 1'b0;
            status_reg    <= 1'b0;
            res_read_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            ring_last_reg <= ring_last_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            clr_idx_reg   <= clr_idx_next;
            step_reg      <= step_next;
            status_reg    <= status_next;
            res_read_reg  <= res_read_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        offset_reg <= offset_next;
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Checks
    `CDL_ASSERT_IMPL(a_mod_done_in_mod, mod_rsp.done, state_reg == ST_MOD)
    `CDL_ASSERT_NEXT(a_fin_delivers, (state_reg == ST_FIN) && out_free,
                     (state_reg == ST_IDLE) && m_axis_tvalid)
    `CDL_ASSERT_IMPL(a_read_result_kind, (state_reg == ST_FIN) && res_read_reg,
                     (req_reg == REQ_READ) || (req_reg == REQ_PEEK)
                     || (req_reg == REQ_MOVE_READ_NEXT) || (req_reg == REQ_MOVE_READ)
                     || (req_reg == REQ_READ_STEP))

endmodule

`default_nettype wire

>>> src/cdl_mod.sv
// Pointer wrap unit: remainder of a 17-bit sum by the ring length.
`default_nettype none

module cdl_mod
    import cdl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mod_req_t mod_req,
    output mod_rsp_t      mod_rsp
);

    localparam int CNT_W = $clog2(LEN_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] dvd_reg, dvd_next;
    logic [LEN_W-1:0] div_reg, div_next;
    logic [LEN_W-1:0] part_reg, part_next;

    logic [LEN_W-1:0] diff;
    logic [LEN_W:0]   shifted;
    logic [LEN_W:0]   shifted_sub;

    // Fast path terms and one restoring step
    assign diff        = mod_req.dividend - mod_req.divisor;
    assign shifted     = {part_reg, dvd_reg[LEN_W-1]};
    assign shifted_sub = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        part_next = part_reg;
        if (busy_reg)
        begin
            // one quotient bit per cycle, msb first
            dvd_next = {dvd_reg[LEN_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
                part_next = shifted_sub[LEN_W-1:0];
            else
                part_next = shifted[LEN_W-1:0];
            if (cnt_reg == CNT_W'(LEN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (mod_req.start)
        begin
            div_next = mod_req.divisor;
            if (mod_req.dividend < mod_req.divisor)
            begin
                part_next = mod_req.dividend;
                done_next = 1'b1;
            end
            else if (diff < mod_req.divisor)
            begin
                part_next = diff;
                done_next = 1'b1;
            end
            else
            begin
                // pointer far beyond a shortened ring: full remainder
                busy_next = 1'b1;
                cnt_next  = '0;
                dvd_next  = mod_req.dividend;
                part_next = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        part_reg <= part_next;
    end

    assign mod_rsp.done = done_reg;
    assign mod_rsp.rem  = part_reg[PTR_W-1:0];

endmodule

`default_nettype wire
